// ===== src/tfmd_pkg.sv =====
`default_nettype none
package tfmd_pkg;

  localparam int DIM_W   = 10;
  localparam int LUMA_W  = 8;
  localparam int SLOT_W  = 2;

  localparam logic [DIM_W-1:0]  DIM_RESET  = 10'd512;
  localparam logic [LUMA_W-1:0] HIGH_RESET = 8'd150;
  localparam logic [LUMA_W-1:0] LOW_RESET  = 8'd100;
  localparam logic [LUMA_W-1:0] LUMA_MAX   = 8'd255;

  // iir weights out of 256
  localparam logic [LUMA_W-1:0] BACK_KEEP  = 8'd26;
  localparam logic [LUMA_W-1:0] ADAPT_GAIN = 8'(256 - 26);
  localparam logic [LUMA_W-1:0] DIFF_GAIN  = 8'(26 * 5);

  localparam int RES_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HIGH_THRESH  = 2'd2,
    REG_LOW_THRESH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LUMA_W-1:0] slot0;
    logic [LUMA_W-1:0] slot1;
    logic [LUMA_W-1:0] slot2;
    logic [LUMA_W-1:0] back;
    logic [LUMA_W-1:0] thr;
  } store_word_t;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [SLOT_W-1:0] slot;
    logic              first;
    logic              capture;
    logic              reload;
    logic              last;
  } pixel_ctl_t;

  typedef struct packed {
    logic motion;
    logic end_of_frame;
  } result_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    unique case (s)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
                                                  input logic [LUMA_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== src/tfmd_update.sv =====
`default_nettype none
module tfmd_update (
  input  tfmd_pkg::pixel_ctl_t                ctl,
  input  tfmd_pkg::store_word_t               rd,
  input  logic [tfmd_pkg::LUMA_W-1:0]         high_thresh,
  input  logic [tfmd_pkg::LUMA_W-1:0]         low_thresh,
  output tfmd_pkg::store_word_t               wr,
  output logic                                motion
);
  import tfmd_pkg::*;

  store_word_t       upd;
  logic [LUMA_W-1:0] thr;
  logic [LUMA_W-1:0] old1;
  logic [LUMA_W-1:0] old2;
  logic [LUMA_W-1:0] d1;
  logic [LUMA_W-1:0] d2;
  logic [LUMA_W-1:0] db;
  logic [LUMA_W-1:0] thr_floor;
  logic [16:0]       thr_acc;
  logic [15:0]       back_acc;
  logic [SLOT_W-1:0] s_old2;
  logic [SLOT_W-1:0] s_old1;

  function automatic logic [LUMA_W-1:0] pick(input store_word_t w,
                                             input logic [SLOT_W-1:0] s);
    logic [LUMA_W-1:0] v;
    unique case (s)
      2'd0:    v = w.slot0;
      2'd1:    v = w.slot1;
      default: v = w.slot2;
    endcase
    return v;
  endfunction

  always_comb begin
    upd = rd;
    if (ctl.capture) begin
      upd.slot0 = ctl.luma;
      upd.slot1 = ctl.luma;
      upd.slot2 = ctl.luma;
      upd.back  = ctl.luma;
    end
    unique case (ctl.slot)
      2'd0:    upd.slot0 = ctl.luma;
      2'd1:    upd.slot1 = ctl.luma;
      default: upd.slot2 = ctl.luma;
    endcase
    thr = ctl.reload ? high_thresh : rd.thr;
    upd.thr = thr;

    s_old2 = next_slot(ctl.slot);
    s_old1 = next_slot(s_old2);
    old2 = pick(upd, s_old2);
    old1 = pick(upd, s_old1);
    d1 = abs_diff(ctl.luma, old1);
    d2 = abs_diff(ctl.luma, old2);
    db = abs_diff(ctl.luma, upd.back);
    thr_floor = (thr < low_thresh) ? low_thresh : thr;

    thr_acc  = 17'(ADAPT_GAIN) * 17'(thr_floor) + 17'(DIFF_GAIN) * 17'(db);
    back_acc = 16'(BACK_KEEP) * 16'(upd.back) + 16'(ADAPT_GAIN) * 16'(ctl.luma);

    wr     = upd;
    motion = 1'b0;
    if (!ctl.first) begin
      if (d1 > thr && d2 > thr) begin
        motion = 1'b1;
      end else begin
        motion  = (db > thr);
        wr.thr  = thr_acc[16] ? LUMA_MAX : thr_acc[15:8];
        wr.back = back_acc[15:8];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/tfmd_fifo.sv =====
`default_nettype none
module tfmd_fifo (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           push,
  input  tfmd_pkg::result_t                              push_data,
  input  logic                                           pop,
  output logic                                           valid,
  output tfmd_pkg::result_t                              head,
  output logic [$clog2(tfmd_pkg::RES_FIFO_DEPTH+1)-1:0] count
);
  import tfmd_pkg::*;

  localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  result_t          entry [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign valid  = (count != '0);
  assign head   = entry[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/three_frame_motion_detector.sv =====
// three-frame motion detector with adaptive background
//
// pixel channel: pixel_valid / pixel_stall carry one gray word per pixel in
// raster order, with capture_background sampled on a frame's first pixel.
// result channel: result_valid / result_stall carry motion and end_of_frame,
// one word per pixel, in the order the pixels came in.
// config port: cfg_we writes cfg_data into the register chosen by cfg_index
// (frame width, frame height, high threshold, low threshold).
//
// every pixel is one read-modify-write of a single store word holding the
// three frame slots, background and threshold; the store has a registered
// read, and a write-back forwarding path covers a pixel that hits the entry
// written in the previous cycle (tiny frames).
// a taken pixel's result is registered in the s1 stage, then offered from the result queue.
// throughput: one pixel per cycle while pixel_stall is low, set by the single store port pair.
// a four-word result queue absorbs a stalled receiver; pixel_stall rises
// only when the queue plus the word in flight would fill it.
// reset: sizes 512x512, thresholds 150/100, queue empty, learning restarts;
// the store holds nothing valid until the first frame has been written.
`default_nettype none
module three_frame_motion_detector #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [tfmd_pkg::LUMA_W-1:0]       pixel_luma,
  input  logic                              capture_background,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              motion,
  output logic                              end_of_frame,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [tfmd_pkg::DIM_W-1:0]        cfg_data
);
  import tfmd_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(RES_FIFO_DEPTH + 1);

  // configuration
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [LUMA_W-1:0] high_thresh;
  logic [LUMA_W-1:0] low_thresh;

  // raster position and frame control
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  row;
  logic [ADDR_W-1:0] pos;
  logic [SLOT_W-1:0] slot;
  logic              first_pend;
  logic              cap_pend;
  logic              rel_pend;
  logic              first_act;
  logic              cap_act;
  logic              rel_act;

  logic              accept;
  logic              pos_zero;
  logic              line_end;
  logic              last;
  pixel_ctl_t        ctl;

  // store pipeline
  store_word_t       store [DEPTH];
  store_word_t       rd_q;
  store_word_t       rd_word;
  store_word_t       wr_word;
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  pixel_ctl_t        s1_ctl;
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  store_word_t       lw_data;
  logic              s1_motion;

  result_t           res_in;
  result_t           res_head;
  logic [CNT_W-1:0]  fifo_count;

  logic [DIM_W-1:0]  width_sat;
  logic [DIM_W-1:0]  height_sat;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input int maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (int'(v) > maxv) begin
      return DIM_W'(maxv);
    end
    return v;
  endfunction

  assign width_sat  = sat_dim(cfg_data, MAX_WIDTH);
  assign height_sat = sat_dim(cfg_data, MAX_HEIGHT);

  assign pixel_stall = ({1'b0, fifo_count} + (CNT_W+1)'(s1_valid))
                       >= (CNT_W+1)'(RES_FIFO_DEPTH);
  assign accept   = pixel_valid && !pixel_stall;
  assign pos_zero = (pos == '0);
  assign line_end = (col == frame_width - DIM_W'(1));
  assign last     = line_end && (row == frame_height - DIM_W'(1));

  always_comb begin
    ctl.luma    = pixel_luma;
    ctl.slot    = slot;
    ctl.last    = last;
    ctl.first   = pos_zero ? first_pend : first_act;
    ctl.capture = pos_zero ? (cap_pend || capture_background || first_pend) : cap_act;
    ctl.reload  = pos_zero ? (rel_pend || first_pend) : rel_act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sat_dim(DIM_RESET, MAX_WIDTH);
      frame_height <= sat_dim(DIM_RESET, MAX_HEIGHT);
      high_thresh  <= HIGH_RESET;
      low_thresh   <= LOW_RESET;
      col          <= '0;
      row          <= '0;
      pos          <= '0;
      slot         <= '0;
      first_pend   <= 1'b1;
      cap_pend     <= 1'b1;
      rel_pend     <= 1'b1;
      first_act    <= 1'b0;
      cap_act      <= 1'b0;
      rel_act      <= 1'b0;
    end else begin
      if (accept) begin
        if (pos_zero) begin
          first_pend <= 1'b0;
          cap_pend   <= 1'b0;
          rel_pend   <= 1'b0;
        end
        if (last) begin
          col       <= '0;
          row       <= '0;
          pos       <= '0;
          first_act <= 1'b0;
          cap_act   <= 1'b0;
          rel_act   <= 1'b0;
          if (!ctl.first) begin
            slot <= next_slot(slot);
          end
        end else begin
          if (pos_zero) begin
            first_act <= ctl.first;
            cap_act   <= ctl.capture;
            rel_act   <= ctl.reload;
          end
          pos <= pos + ADDR_W'(1);
          if (line_end) begin
            col <= '0;
            row <= row + DIM_W'(1);
          end else begin
            col <= col + DIM_W'(1);
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
            if ((cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) ?
                (width_sat != frame_width) : (height_sat != frame_height)) begin
              if (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) begin
                frame_width <= width_sat;
              end else begin
                frame_height <= height_sat;
              end
              first_pend <= 1'b1;
              cap_pend   <= 1'b1;
              rel_pend   <= 1'b1;
              first_act  <= 1'b0;
              cap_act    <= 1'b0;
              rel_act    <= 1'b0;
              col        <= '0;
              row        <= '0;
              pos        <= '0;
              slot       <= '0;
            end
          end
          REG_HIGH_THRESH: begin
            if (cfg_data[LUMA_W-1:0] >= low_thresh) begin
              high_thresh <= cfg_data[LUMA_W-1:0];
              rel_pend    <= 1'b1;
            end
          end
          REG_LOW_THRESH: begin
            if (cfg_data[LUMA_W-1:0] <= high_thresh) begin
              low_thresh <= cfg_data[LUMA_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // store: read at acceptance, written back from the s1 stage in the next cycle
  always_ff @(posedge clk) begin
    rd_q <= store[pos];
    if (s1_valid) begin
      store[s1_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      lw_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= pos;
      s1_ctl  <= ctl;
    end
    if (s1_valid) begin
      lw_addr <= s1_addr;
      lw_data <= wr_word;
    end
  end

  // the entry written on the edge of this pixel's read is still old in rd_q
  assign rd_word = (lw_valid && lw_addr == s1_addr) ? lw_data : rd_q;

  tfmd_update u_update (
    .ctl         (s1_ctl),
    .rd          (rd_word),
    .high_thresh (high_thresh),
    .low_thresh  (low_thresh),
    .wr          (wr_word),
    .motion      (s1_motion)
  );

  assign res_in.motion       = s1_motion;
  assign res_in.end_of_frame = s1_ctl.last;

  tfmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (res_in),
    .pop       (!result_stall),
    .valid     (result_valid),
    .head      (res_head),
    .count     (fifo_count)
  );

  assign motion       = res_head.motion;
  assign end_of_frame = res_head.end_of_frame;

endmodule
`default_nettype wire

// ===== src/tfmd_checker.sv =====
`default_nettype none
module tfmd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              pixel_valid,
  input logic                              pixel_stall,
  input logic                              result_valid,
  input logic                              result_stall
);

  logic pixel_take;
  assign pixel_take = pixel_valid && !pixel_stall;

  // a waiting word is not withdrawn
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered right after reset");

  // a fresh result only appears after a pixel was taken, by way of the s1 stage and the result queue
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_take, 2))
    else $error("result word with no pixel behind it");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !pixel_stall)
    else $error("pixel stalled with empty result side");

endmodule

bind three_frame_motion_detector tfmd_checker u_tfmd_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_three_frame_motion_detector.sv =====
`timescale 1ns / 100ps
module tb_three_frame_motion_detector;
  import tfmd_pkg::*;

  localparam int unsigned DIM_MAX        = 512;
  localparam int unsigned PIX_MAX        = DIM_MAX * DIM_MAX;
  localparam int unsigned ITEM_TARGET    = 1850;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned HOLD_LONG      = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // iir weights out of 256
  localparam int unsigned BACK_OLD_W = 26;
  localparam int unsigned BACK_NEW_W = 230;
  localparam int unsigned THR_OLD_W  = 230;
  localparam int unsigned THR_DIFF_W = 130;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              capture;
  } pixel_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [LUMA_W-1:0] pixel_luma = '0;
  logic              capture_background = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              motion;
  logic              end_of_frame;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;

  three_frame_motion_detector #(
    .MAX_WIDTH  (DIM_MAX),
    .MAX_HEIGHT (DIM_MAX)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .pixel_valid        (pixel_valid),
    .pixel_stall        (pixel_stall),
    .pixel_luma         (pixel_luma),
    .capture_background (capture_background),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .motion             (motion),
    .end_of_frame       (end_of_frame),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // detector state as the testbench sees it
  // ---------------------------------------------------------------------------
  bit [7:0]    luma_hist [3*PIX_MAX];
  bit [7:0]    back_luma [PIX_MAX];
  bit [7:0]    pix_thr   [PIX_MAX];
  int unsigned slot_now, pix_pos;
  bit          first_due, capture_due, reload_due;
  bit          first_frame, capture_frame, reload_frame;
  int unsigned fw, fh, thr_high, thr_low;

  result_t     motion_due [$];
  pixel_word_t pix_q [$];
  int unsigned n_items = 0;
  int unsigned fail_count = 0;

  function automatic int unsigned luma_dist(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic void restart_learning();
    first_due     = 1'b1;
    capture_due   = 1'b1;
    reload_due    = 1'b1;
    first_frame   = 1'b0;
    capture_frame = 1'b0;
    reload_frame  = 1'b0;
    pix_pos       = 0;
    slot_now      = 0;
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    int unsigned v;
    case (idx)
      REG_FRAME_WIDTH: begin
        v = clip_dim(val);
        if (v != fw) begin
          fw = v;
          restart_learning();
        end
      end
      REG_FRAME_HEIGHT: begin
        v = clip_dim(val);
        if (v != fh) begin
          fh = v;
          restart_learning();
        end
      end
      REG_HIGH_THRESH: begin
        v = val[LUMA_W-1:0];
        if (v >= thr_low) begin
          thr_high   = v;
          reload_due = 1'b1;
        end
      end
      REG_LOW_THRESH: begin
        v = val[LUMA_W-1:0];
        if (v <= thr_high) thr_low = v;
      end
      default: ;
    endcase
  endfunction

  // works out motion and end of frame for one pixel and queues them
  function automatic void predict_motion(input logic [LUMA_W-1:0] luma, input logic cap_req);
    int unsigned area, p, s, cur, older, oldest, thr, back, d_older, d_oldest, d_back, t;
    result_t r;
    area = fw * fh;
    if (pix_pos >= area) pix_pos = 0;
    if (slot_now >= 3) slot_now = 0;
    p = pix_pos;
    s = slot_now;
    cur = luma;
    r.motion = 1'b0;

    if (p == 0) begin
      first_frame   = first_due;
      capture_frame = capture_due || cap_req || first_due;
      reload_frame  = reload_due || first_due;
      first_due     = 1'b0;
      capture_due   = 1'b0;
      reload_due    = 1'b0;
    end

    if (reload_frame) pix_thr[p] = thr_high[7:0];
    luma_hist[s*PIX_MAX + p] = luma;
    if (capture_frame) begin
      back_luma[p]                = luma;
      luma_hist[p]                = luma;
      luma_hist[PIX_MAX + p]      = luma;
      luma_hist[2*PIX_MAX + p]    = luma;
    end

    if (!first_frame) begin
      oldest   = luma_hist[((s + 1) % 3)*PIX_MAX + p];
      older    = luma_hist[((s + 2) % 3)*PIX_MAX + p];
      thr      = pix_thr[p];
      back     = back_luma[p];
      d_older  = luma_dist(cur, older);
      d_oldest = luma_dist(cur, oldest);
      if (d_older > thr && d_oldest > thr) begin
        r.motion = 1'b1;
      end else begin
        d_back = luma_dist(cur, back);
        if (d_back > thr) r.motion = 1'b1;
        if (thr < thr_low) thr = thr_low;
        t = (THR_OLD_W * thr + THR_DIFF_W * d_back) >> 8;
        if (t > 255) t = 255;
        pix_thr[p]   = t[7:0];
        t = (BACK_OLD_W * back + BACK_NEW_W * cur) >> 8;
        back_luma[p] = t[7:0];
      end
    end

    r.end_of_frame = (p + 1 >= area);
    if (r.end_of_frame) begin
      pix_pos = 0;
      if (!first_frame) slot_now = (s + 1) % 3;
      first_frame   = 1'b0;
      capture_frame = 1'b0;
      reload_frame  = 1'b0;
    end else begin
      pix_pos = p + 1;
    end
    motion_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  logic        pix_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned calm_items = 0;
  pixel_word_t next_word;

  function automatic int unsigned next_gap();
    int unsigned roll;
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 62) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    if (roll < 98) return $urandom_range(20, 40);
    calm_items = $urandom_range(30, 80);
    return 0;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_taken) begin
      if (gap_left != 0) begin
        pixel_valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pix_q.size() != 0) begin
        next_word = pix_q.pop_front();
        pixel_valid        <= 1'b1;
        pixel_luma         <= next_word.luma;
        capture_background <= next_word.capture;
        gap_left           <= next_gap();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver
  // ---------------------------------------------------------------------------
  bit          long_hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  int unsigned stall_roll;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (long_hold_req) begin
      // long hold so the result queue fills and the pixel side backs up
      long_hold_req = 1'b0;
      result_stall <= 1'b1;
      stall_left   <= HOLD_LONG - 1;
    end else if (free_left != 0) begin
      result_stall <= 1'b0;
      free_left    <= free_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 68) begin
        result_stall <= 1'b0;
      end else if (stall_roll < 92) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 3);
      end else if (stall_roll < 96) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(10, 30);
      end else begin
        result_stall <= 1'b0;
        free_left    <= $urandom_range(20, 100);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor, checker and watchdog
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;
  result_t     want;

  always @(posedge clk) begin
    if (rst) begin
      pix_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      pix_taken <= pixel_valid && !pixel_stall;
      if (pixel_valid && !pixel_stall) predict_motion(pixel_luma, capture_background);
      if (result_valid && !result_stall) begin
        if (motion_due.size() == 0) begin
          $display("%0t: unexpected word motion=%0b end_of_frame=%0b",
                   $time, motion, end_of_frame);
          fail_count++;
        end else begin
          want = motion_due.pop_front();
          if (motion !== want.motion) begin
            $display("%0t: motion expected %0b actual %0b", $time, want.motion, motion);
            fail_count++;
          end
          if (end_of_frame !== want.end_of_frame) begin
            $display("%0t: end_of_frame expected %0b actual %0b",
                     $time, want.end_of_frame, end_of_frame);
            fail_count++;
          end
        end
      end
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [LUMA_W-1:0] l, input logic c);
    pixel_word_t w;
    w.luma    = l;
    w.capture = c;
    pix_q.push_back(w);
    n_items++;
  endtask

  // waits until every pixel is taken and every result has come back;
  // checked on the rising edge, where the driver's queue and valid are stable
  task automatic settle();
    do @(posedge clk);
    while (pix_q.size() != 0 || pixel_valid || motion_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DIM_W-1:0] thresh_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DIM_W'(255);
      2:       return DIM_W'($urandom_range(0, 1023));
      default: return DIM_W'($urandom_range(20, 200));
    endcase
  endfunction

  task automatic retune();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_LOW_THRESH, thresh_value());
      write_reg(REG_HIGH_THRESH, thresh_value());
    end else begin
      write_reg(REG_HIGH_THRESH, thresh_value());
      write_reg(REG_LOW_THRESH, thresh_value());
    end
  endtask

  // a few frames of one scene: small noise, moving patches, random and hard
  // black/white frames; the last pass is a partial frame of tail pixels
  task automatic play_scene(input logic [DIM_W-1:0] w_data, input logic [DIM_W-1:0] h_data,
                            input int unsigned frames, input int unsigned tail,
                            input bit may_retune);
    bit [7:0]    scene [$];
    int unsigned area, f, p, n, mode, lo, hi, split;
    int          v;
    logic [7:0]  luma;
    settle();
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
    if (may_retune && $urandom_range(0, 1)) retune();
    @(posedge clk);
    area = fw * fh;
    for (p = 0; p < area; p++) scene.push_back(8'($urandom_range(0, 255)));
    for (f = 0; f <= frames; f++) begin
      n     = (f == frames) ? tail : area;
      mode  = $urandom_range(0, 9);
      lo    = $urandom_range(0, area - 1);
      hi    = $urandom_range(lo, area - 1);
      split = area;
      if (may_retune && area > 1 && $urandom_range(0, 4) == 0)
        split = $urandom_range(1, area - 1);
      for (p = 0; p < n; p++) begin
        if (p == split) begin
          // threshold change in the middle of a frame
          settle();
          retune();
          @(posedge clk);
        end
        case (mode)
          6, 7:    luma = (p >= lo && p <= hi) ? ~scene[p] : scene[p];
          8:       luma = 8'($urandom_range(0, 255));
          9:       luma = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          default: begin
            v = scene[p] + $urandom_range(0, 24) - 12;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            luma     = v[7:0];
            scene[p] = luma;
          end
        endcase
        push_pixel(luma, (p == 0) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 24) == 0));
      end
      if (may_retune && f < frames && $urandom_range(0, 3) == 0) begin
        settle();
        retune();
        @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned k, w, h, frames, tail;
    fw       = DIM_MAX;
    fh       = DIM_MAX;
    thr_high = 150;
    thr_low  = 100;
    restart_learning();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x2 frames, width written as zero
    write_reg(REG_FRAME_WIDTH, DIM_W'(0));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
    @(posedge clk);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);     // differs from both older frames
    push_pixel(8'd0, 1'b1);       // capture off the first pixel is ignored
    push_pixel(8'd0, 1'b1);       // capture on the first pixel
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    settle();
    write_reg(REG_HIGH_THRESH, DIM_W'(50));    // under the floor, dropped
    write_reg(REG_LOW_THRESH, DIM_W'(200));    // over the high level, dropped
    write_reg(REG_LOW_THRESH, DIM_W'(0));
    write_reg(REG_HIGH_THRESH, DIM_W'(255));
    @(posedge clk);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    settle();
    write_reg(REG_HIGH_THRESH, DIM_W'(0));
    @(posedge clk);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    settle();
    // single-pixel frames hit the same store entry back to back
    write_reg(REG_FRAME_HEIGHT, DIM_W'(1));
    @(posedge clk);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd200, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);

    k = 0;
    while (n_items < ITEM_TARGET) begin
      case (k)
        1: play_scene(DIM_W'(1023), DIM_W'(1), 1, 64, 1'b0);
        2: begin
          play_scene(DIM_W'(8), DIM_W'(6), 4, 0, 1'b0);
          long_hold_req = 1'b1;
        end
        3: play_scene(DIM_W'(0), DIM_W'(DIM_MAX), 1, 64, 1'b0);
        default: begin
          w      = $urandom_range(1, 8);
          h      = $urandom_range(1, 6);
          frames = $urandom_range(2, 6);
          tail   = ($urandom_range(0, 2) == 0 && w * h > 1) ? $urandom_range(1, w * h - 1) : 0;
          play_scene(DIM_W'(w), DIM_W'(h), frames, tail, 1'b1);
        end
      endcase
      k++;
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && motion_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
